// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the fixed-point ALU.
// Needs clk and rst_n in the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
// Shared constants, action codes, types and saturation helpers for the fixed-point ALU.
// No dependencies.
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;

  localparam logic [3:0] ACT_ADD      = 4'd0;
  localparam logic [3:0] ACT_SUB      = 4'd1;
  localparam logic [3:0] ACT_MUL      = 4'd2;
  localparam logic [3:0] ACT_DIV      = 4'd3;
  localparam logic [3:0] ACT_MIN      = 4'd4;
  localparam logic [3:0] ACT_MAX      = 4'd5;
  localparam logic [3:0] ACT_INC      = 4'd6;
  localparam logic [3:0] ACT_DEC      = 4'd7;
  localparam logic [3:0] ACT_TO_INT   = 4'd8;
  localparam logic [3:0] ACT_FROM_INT = 4'd9;

  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg;
    logic        dbz;
    logic        less;
    logic        equal;
    logic        ovf;
    logic [31:0] res;
  } tag_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  function automatic sat_t pack_mag(input logic neg, input logic [63:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        s.res = 32'h8000_0000;
        s.ovf = 1'b1;
      end else begin
        s.res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        s.res = 32'h7FFF_FFFF;
        s.ovf = 1'b1;
      end else begin
        s.res = mag[31:0];
      end
    end
    return s;
  endfunction

  function automatic sat_t sat_sum(input logic [32:0] sum);
    sat_t s;
    s.ovf = (sum[32] != sum[31]);
    if (sum[32] != sum[31]) begin
      s.res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      s.res = sum[31:0];
    end
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== design/fpa_front.sv =====
// Front stages: operand magnitudes and compare, simple actions, multiplier and its rounding.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS,
  localparam int QW = 32 + FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [3:0]         in_action,
  input  wire logic signed [31:0] in_a,
  input  wire logic signed [31:0] in_b,
  output fpa_pkg::tag_t           tag_o,
  output logic [31:0]             mb_o,
  output logic [QW-1:0]           num_o
);
  logic              v1_r, v2_r;
  logic [3:0]        act1_r, act2_r;
  logic signed [31:0] a1_r, b1_r;
  logic [31:0]       ma1_r, mb1_r, ma2_r, mb2_r, ma3_r, mb3_r;
  logic              neg1_r, less1_r, eq1_r;
  fpa_pkg::tag_t     tag2_r, tag3_r, tag2_nxt, tag3_nxt;
  logic [63:0]       prod2_r, rnd;
  logic [31:0]       ma_nxt, mb_nxt;
  fpa_pkg::sat_t     simple;

  assign ma_nxt = in_a[31] ? (32'd0 - in_a) : in_a;
  assign mb_nxt = in_b[31] ? (32'd0 - in_b) : in_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    act1_r  <= in_action;
    a1_r    <= in_a;
    b1_r    <= in_b;
    ma1_r   <= ma_nxt;
    mb1_r   <= mb_nxt;
    neg1_r  <= in_a[31] ^ in_b[31];
    less1_r <= (in_a < in_b);
    eq1_r   <= (in_a == in_b);
  end

  always_comb begin
    simple = '0;
    case (act1_r)
      fpa_pkg::ACT_ADD:      simple = fpa_pkg::sat_sum({a1_r[31], a1_r} + {b1_r[31], b1_r});
      fpa_pkg::ACT_SUB:      simple = fpa_pkg::sat_sum({a1_r[31], a1_r} - {b1_r[31], b1_r});
      fpa_pkg::ACT_MIN:      simple.res = (less1_r || eq1_r) ? a1_r : b1_r;
      fpa_pkg::ACT_MAX:      simple.res = (less1_r || eq1_r) ? b1_r : a1_r;
      fpa_pkg::ACT_INC:      simple = fpa_pkg::sat_sum({a1_r[31], a1_r} + 33'd1);
      fpa_pkg::ACT_DEC:      simple = fpa_pkg::sat_sum({a1_r[31], a1_r} - 33'd1);
      fpa_pkg::ACT_TO_INT:   simple.res = 32'(a1_r >>> FRAC_BITS);
      fpa_pkg::ACT_FROM_INT: simple = fpa_pkg::pack_mag(a1_r[31],
                               64'({ma1_r, {FRAC_BITS{1'b0}}}));
      default:               simple = '0;
    endcase
    tag2_nxt.valid  = v1_r;
    tag2_nxt.is_div = (act1_r == fpa_pkg::ACT_DIV);
    tag2_nxt.neg    = neg1_r;
    tag2_nxt.dbz    = (act1_r == fpa_pkg::ACT_DIV) && (mb1_r == 32'd0);
    tag2_nxt.less   = less1_r;
    tag2_nxt.equal  = eq1_r;
    tag2_nxt.ovf    = simple.ovf;
    tag2_nxt.res    = simple.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    tag2_r  <= tag2_nxt;
    act2_r  <= act1_r;
    prod2_r <= ma1_r * mb1_r;
    ma2_r   <= ma1_r;
    mb2_r   <= mb1_r;
  end

  assign rnd = (prod2_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_comb begin
    fpa_pkg::sat_t m;
    m = fpa_pkg::pack_mag(tag2_r.neg, rnd);
    tag3_nxt       = tag2_r;
    tag3_nxt.valid = v2_r;
    if (act2_r == fpa_pkg::ACT_MUL) begin
      tag3_nxt.res = m.res;
      tag3_nxt.ovf = m.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r.valid <= 1'b0;
    end else begin
      tag3_r.valid <= tag3_nxt.valid;
    end
    tag3_r.is_div <= tag3_nxt.is_div;
    tag3_r.neg    <= tag3_nxt.neg;
    tag3_r.dbz    <= tag3_nxt.dbz;
    tag3_r.less   <= tag3_nxt.less;
    tag3_r.equal  <= tag3_nxt.equal;
    tag3_r.ovf    <= tag3_nxt.ovf;
    tag3_r.res    <= tag3_nxt.res;
    ma3_r <= ma2_r;
    mb3_r <= mb2_r;
  end

  assign tag_o = tag3_r;
  assign mb_o  = mb3_r;
  assign num_o = {ma3_r, {FRAC_BITS{1'b0}}};
endmodule
`default_nettype wire

// ===== design/fpa_div_step.sv =====
// One restoring-division stage: shift in one dividend bit, subtract, emit one quotient bit.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_step #(
  parameter int QW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fpa_pkg::tag_t tag_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [QW-1:0] quo_i,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [31:0]   mb_i,
  output fpa_pkg::tag_t      tag_o,
  output logic [31:0]        rem_o,
  output logic [QW-1:0]      quo_o,
  output logic [QW-1:0]      num_o,
  output logic [31:0]        mb_o
);
  logic [32:0]   rem_sh, diff;
  logic          ge;
  fpa_pkg::tag_t tag_r;
  logic [31:0]   rem_r, mb_r;
  logic [QW-1:0] quo_r, num_r;

  assign rem_sh = {rem_i, num_i[QW-1]};
  assign ge     = (rem_sh >= {1'b0, mb_i});
  assign diff   = rem_sh - {1'b0, mb_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_i.valid;
    end
    tag_r.is_div <= tag_i.is_div;
    tag_r.neg    <= tag_i.neg;
    tag_r.dbz    <= tag_i.dbz;
    tag_r.less   <= tag_i.less;
    tag_r.equal  <= tag_i.equal;
    tag_r.ovf    <= tag_i.ovf;
    tag_r.res    <= tag_i.res;
    rem_r <= ge ? diff[31:0] : rem_sh[31:0];
    quo_r <= {quo_i[QW-2:0], ge};
    num_r <= {num_i[QW-2:0], 1'b0};
    mb_r  <= mb_i;
  end

  assign tag_o = tag_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign num_o = num_r;
  assign mb_o  = mb_r;
endmodule
`default_nettype wire

// ===== design/fpa_finish.sv =====
// Final stage: rounds and saturates the quotient, selects the result, drives the output register.
// Depends on fpa_pkg.
`default_nettype none
module fpa_finish #(
  parameter int QW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fpa_pkg::tag_t tag_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [QW-1:0] quo_i,
  input  wire logic [31:0]   mb_i,
  output logic               strobe_o,
  output logic [31:0]        result_o,
  output logic               less_o,
  output logic               equal_o,
  output logic               ovf_o,
  output logic               dbz_o
);
  logic          up;
  logic [63:0]   qr;
  fpa_pkg::sat_t q;
  logic          strobe_r, less_r, equal_r, ovf_r, dbz_r;
  logic [31:0]   result_r, result_nxt;
  logic          ovf_nxt;

  assign up = ({rem_i, 1'b0} >= {1'b0, mb_i});
  assign qr = 64'(quo_i) + 64'(up);
  assign q  = fpa_pkg::pack_mag(tag_i.neg, qr);

  always_comb begin
    result_nxt = tag_i.res;
    ovf_nxt    = tag_i.ovf;
    if (tag_i.dbz) begin
      result_nxt = 32'd0;
      ovf_nxt    = 1'b0;
    end else if (tag_i.is_div) begin
      result_nxt = q.res;
      ovf_nxt    = q.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= tag_i.valid;
    end
    result_r <= result_nxt;
    ovf_r    <= ovf_nxt;
    dbz_r    <= tag_i.dbz;
    less_r   <= tag_i.less;
    equal_r  <= tag_i.equal;
  end

  assign strobe_o = strobe_r;
  assign result_o = result_r;
  assign less_o   = less_r;
  assign equal_o  = equal_r;
  assign ovf_o    = ovf_r;
  assign dbz_o    = dbz_r;
endmodule
`default_nettype wire

// ===== design/fixed_point_alu_q24_8_unit.sv =====
// Top level of the signed fixed-point ALU: front stages, divider chain, finish stage.
// Depends on fpa_pkg, fpa_front, fpa_div_step, fpa_finish and assert_macros.svh.
//
//   channel  ports                                   transfer
//   input    in_action, in_operand_a, in_operand_b   start && !busy
//   result   out_result, out_less, out_equal,        out_strobe
//            out_overflow, out_divide_by_zero
//
// One item per cycle while busy is low; every item leaves in the order of its transfer.
// The restoring divider computes one quotient bit per stage.
// busy is high during reset and the first cycle after it; items in flight at reset are dropped.
// The receiver cannot stall, so no stage ever holds.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_q24_8_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_action,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_strobe,
  output logic signed [31:0]      out_result,
  output logic                    out_less,
  output logic                    out_equal,
  output logic                    out_overflow,
  output logic                    out_divide_by_zero
);
  localparam int QW  = 32 + FRAC_BITS;
  localparam int LAT = QW + 4;

  logic          busy_r;
  logic          accept;
  fpa_pkg::tag_t tag_w [0:QW];
  logic [31:0]   rem_w [0:QW];
  logic [31:0]   mb_w  [0:QW];
  logic [QW-1:0] quo_w [0:QW];
  logic [QW-1:0] num_w [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_action (in_action),
    .in_a      (in_operand_a),
    .in_b      (in_operand_b),
    .tag_o     (tag_w[0]),
    .mb_o      (mb_w[0]),
    .num_o     (num_w[0])
  );

  assign rem_w[0] = 32'd0;
  assign quo_w[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step #(.QW(QW)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (tag_w[i]),
      .rem_i (rem_w[i]),
      .quo_i (quo_w[i]),
      .num_i (num_w[i]),
      .mb_i  (mb_w[i]),
      .tag_o (tag_w[i+1]),
      .rem_o (rem_w[i+1]),
      .quo_o (quo_w[i+1]),
      .num_o (num_w[i+1]),
      .mb_o  (mb_w[i+1])
    );
  end

  fpa_finish #(.QW(QW)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_i    (tag_w[QW]),
    .rem_i    (rem_w[QW]),
    .quo_i    (quo_w[QW]),
    .mb_i     (mb_w[QW]),
    .strobe_o (out_strobe),
    .result_o (out_result),
    .less_o   (out_less),
    .equal_o  (out_equal),
    .ovf_o    (out_overflow),
    .dbz_o    (out_divide_by_zero)
  );

  `FPA_ASSERT_NOW(a_latency, 1'b1, out_strobe == $past(accept, LAT), "strobe latency mismatch")
  `FPA_ASSERT_NOW(a_dbz_zero, out_strobe && out_divide_by_zero,
    out_result == 32'd0 && !out_overflow, "divide by zero result not clean")
  `FPA_ASSERT_NOW(a_cmp_excl, out_strobe && out_equal, !out_less, "less and equal both set")
endmodule
`default_nettype wire

// ===== sim/tb_fixed_point_alu_q24_8_unit.sv =====
// Self-checking testbench for the Q24.8 fixed-point ALU: random and directed commands,
// predicted results compared in order with the strobed outputs.
// Depends on fpa_pkg and fixed_point_alu_q24_8_unit.
`timescale 1ns / 1ps
module tb_fixed_point_alu_q24_8_unit;
  localparam int LATENCY   = fpa_pkg::FRAC_BITS + 36;
  localparam int MAX_CYCLES = 200000;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result;
    logic        less;
    logic        equal;
    logic        ovf;
    logic        dbz;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_action = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_strobe;
  logic signed [31:0] out_result;
  logic out_less, out_equal, out_overflow, out_divide_by_zero;

  cmd_t     pending_cmds[$];
  alu_out_t expected_outs[$];
  int       errors = 0;
  int       cycles = 0;
  bit       stim_done = 0;
  int       burst_left = 0;
  int       gap_left = 0;

  fixed_point_alu_q24_8_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alu_out_t saturate(input logic neg, input logic [63:0] mag);
    alu_out_t o;
    o = '0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        o.result = 32'h8000_0000;
        o.ovf = 1'b1;
      end else o.result = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        o.result = 32'h7FFF_FFFF;
        o.ovf = 1'b1;
      end else o.result = mag[31:0];
    end
    return o;
  endfunction

  function automatic alu_out_t compute_alu(input cmd_t c);
    alu_out_t o;
    longint sa, sb, s;
    logic [63:0] ma, mb, p, n, q, r;
    logic neg;
    sa = $signed(c.a);
    sb = $signed(c.b);
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    neg = (sa < 0) != (sb < 0);
    o = '0;
    case (c.action)
      fpa_pkg::ACT_ADD: begin
        s = sa + sb;
        o = saturate(s < 0, s < 0 ? -s : s);
      end
      fpa_pkg::ACT_SUB: begin
        s = sa - sb;
        o = saturate(s < 0, s < 0 ? -s : s);
      end
      fpa_pkg::ACT_MUL: begin
        p = ma * mb;
        o = saturate(neg, (p + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS);
      end
      fpa_pkg::ACT_DIV: begin
        if (mb == 0) o.dbz = 1'b1;
        else begin
          n = ma << fpa_pkg::FRAC_BITS;
          q = n / mb;
          r = n % mb;
          if (2 * r >= mb) q = q + 1;
          o = saturate(neg, q);
        end
      end
      fpa_pkg::ACT_MIN: o.result = (sa <= sb) ? c.a : c.b;
      fpa_pkg::ACT_MAX: o.result = (sa >= sb) ? c.a : c.b;
      fpa_pkg::ACT_INC: begin
        s = sa + 1;
        o = saturate(s < 0, s < 0 ? -s : s);
      end
      fpa_pkg::ACT_DEC: begin
        s = sa - 1;
        o = saturate(s < 0, s < 0 ? -s : s);
      end
      fpa_pkg::ACT_TO_INT: o.result = $signed(c.a) >>> fpa_pkg::FRAC_BITS;
      fpa_pkg::ACT_FROM_INT: o = saturate(sa < 0, ma << fpa_pkg::FRAC_BITS);
      default: o.result = '0;
    endcase
    o.less = sa < sb;
    o.equal = sa == sb;
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 600) - 300;
      3: return ($urandom_range(0, 2000) - 1000) << fpa_pkg::FRAC_BITS;
      4: return $signed($urandom()) >>> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && !busy && start) begin
      expected_outs.push_back(compute_alu({in_action, in_operand_a, in_operand_b}));
    end
    if (!rst_n || (start && busy)) begin
      // hold the current command
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      cmd_t c;
      c = pending_cmds.pop_front();
      start <= 1'b1;
      in_action <= c.action;
      in_operand_a <= c.a;
      in_operand_b <= c.b;
      if (burst_left > 1) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_result);
        errors <= errors + 1;
      end else begin
        alu_out_t e, g;
        e = expected_outs.pop_front();
        g = {out_result, out_less, out_equal, out_overflow, out_divide_by_zero};
        if (g !== e) begin
          $display("%0t: expected res=%h lt=%b eq=%b ovf=%b dbz=%b,",
                   $time, e.result, e.less, e.equal, e.ovf, e.dbz,
                   " got res=%h lt=%b eq=%b ovf=%b dbz=%b",
                   g.result, g.less, g.equal, g.ovf, g.dbz);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cmd_t c;
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h100, 32'hFFFF_FF00, 32'h80};
    for (int k = 0; k < 16; k++) begin
      c.action = k[3:0];
      c.a = edge_vals[k % 6];
      c.b = edge_vals[(k + 2) % 6];
      pending_cmds.push_back(c);
    end
    pending_cmds.push_back('{fpa_pkg::ACT_DIV, 32'h100, 32'h0});
    pending_cmds.push_back('{fpa_pkg::ACT_MIN, 32'h55, 32'h55});
    pending_cmds.push_back('{fpa_pkg::ACT_INC, 32'h7FFF_FFFF, 32'h0});
    pending_cmds.push_back('{fpa_pkg::ACT_DEC, 32'h8000_0000, 32'h0});
    pending_cmds.push_back('{fpa_pkg::ACT_TO_INT, 32'hFFFF_FF01, 32'h0});
    pending_cmds.push_back('{fpa_pkg::ACT_FROM_INT, 32'h0080_0000, 32'h0});
    pending_cmds.push_back('{fpa_pkg::ACT_MUL, 32'h80, 32'hFFFF_FF01});
    pending_cmds.push_back('{fpa_pkg::ACT_DIV, 32'h1, 32'h200});
    for (int k = 0; k < 2000; k++) begin
      c.action = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
      c.a = rand_operand();
      c.b = ($urandom_range(0, 9) == 0) ? c.a : rand_operand();
      pending_cmds.push_back(c);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    @(posedge clk);
    wait (expected_outs.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_outs.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
